// ===== design/sfc_pkg.sv =====
// shared constants, types and helpers for the segment fir convolver
package sfc_pkg;

   localparam int SAMPLE_BITS      = 16;
   localparam int MAX_TAPS_DEFAULT = 1024;
   localparam int TAP_COUNT_BITS   = 11;
   localparam int TAP_ADDR_BITS    = 10;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 16;
   localparam int MAX_VALID_ROWS   = 256;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_ADDRESS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_VALUE   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // taps per tap memory row, so that the row count stays within the valid flops
   function automatic int tap_lanes(input int max_taps);
      int lanes;
      lanes = 1;
      for (int i = 0; i < 16; i++) begin
         if (lanes * MAX_VALID_ROWS < max_taps) begin
            lanes = lanes * 2;
         end
      end
      return lanes;
   endfunction

endpackage

// ===== design/sfc_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module sfc_ram #(
   parameter int WIDTH = sfc_pkg::SAMPLE_BITS,
   parameter int DEPTH = sfc_pkg::MAX_TAPS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/segment_fir_convolver.sv =====
// stereo direct-form fir over a marked segment of a sample stream, top level
//
// Each transaction walks N taps, N being tap_count clamped to MAX_TAPS:
// the multiply-accumulate loop reads one tap-memory row and one history entry per tap
// through the single read port of each memory, both channels sharing the tap read.
// One item is processed at a time; the next item may be accepted while the previous
// result still waits on the rsp side. The history starts out as zero without a clearing
// pass (the write pointer tracks which entries were written since reset), and the tap
// store reads as zero until written through per-row valid flops, so the block is ready
// right after reset. A tap_value write takes a read-modify-write of its row and holds
// req_tready low for the following cycle.
module segment_fir_convolver #(
   parameter int MAX_TAPS = sfc_pkg::MAX_TAPS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [2*sfc_pkg::SAMPLE_BITS-1:0]    req_tdata,   // right_sample, left_sample
   input  logic                                 req_tuser,   // in_segment
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [2*sfc_pkg::SAMPLE_BITS-1:0]    rsp_tdata,   // right_out, left_out
   output logic                                 rsp_tuser,   // saturated
   input  logic                                 csr_we,
   input  logic [sfc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sfc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int SB    = sfc_pkg::SAMPLE_BITS;
   localparam int FRAC  = SB - 1;
   localparam int PW    = 2 * SB;
   localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW    = $clog2(MAX_TAPS + 1);
   localparam int LANES = sfc_pkg::tap_lanes(MAX_TAPS);
   localparam int LB    = $clog2(LANES);
   localparam int LW    = (LB > 0) ? LB : 1;
   localparam int ROWS  = (MAX_TAPS + LANES - 1) / LANES;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ACC_W = 2 * SB + CW + 1;

   localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF    = {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

   // configuration registers
   logic [sfc_pkg::TAP_COUNT_BITS-1:0] tap_count_ff, tap_count_in;
   logic [sfc_pkg::TAP_ADDR_BITS-1:0]  tap_address_ff, tap_address_in;
   logic                               tap_wr;
   logic [RW-1:0]                      csr_row;
   logic [LW-1:0]                      csr_lane;

   // tap row read-modify-write
   logic                wr_pend_ff, wr_pend_in;
   logic [RW-1:0]       wr_row_ff;
   logic [LW-1:0]       wr_lane_ff;
   logic [SB-1:0]       wr_value_ff;
   logic                last_valid_ff, last_valid_in;
   logic [RW-1:0]       last_row_ff;
   logic [LANES*SB-1:0] last_data_ff;
   logic [LANES*SB-1:0] row_base;
   logic [LANES*SB-1:0] row_merged;
   logic [ROWS-1:0]     row_valid_ff, row_valid_in;

   // memories
   logic [RW-1:0]       tap_raddr;
   logic [LANES*SB-1:0] tap_rdata;
   logic [AW-1:0]       hist_raddr;
   logic [PW-1:0]       hist_wdata;
   logic [PW-1:0]       hist_rdata;

   // sequencer
   sfc_pkg::state_type state_ff, state_in;
   logic               accept;
   logic               issue_en;
   logic               finish_load;
   logic               out_free;
   logic [31:0]        n_full;
   logic [CW-1:0]      n_taps;
   logic [CW-1:0]      k_ff, k_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic               wrapped_ff, wrapped_in;
   logic [RW-1:0]      k_row;
   logic [LW-1:0]      k_lane;
   logic [CW:0]        k_ext, p_ext, idx_full;
   logic               k_le_p;

   // mac pipeline
   logic                    s1_valid_ff, s1_valid_in;
   logic [LW-1:0]           s1_lane_ff;
   logic                    s1_tap_ok_ff;
   logic                    s1_hist_ok_ff;
   logic signed [SB-1:0]    tap_s, hist_l_s, hist_r_s;
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [PW-1:0]    prod_l_ff, prod_r_ff;
   logic signed [ACC_W-1:0] acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;

   // result register
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [PW-1:0] rsp_tdata_ff;
   logic          rsp_tuser_ff;
   logic [SB:0]   out_l, out_r;

   function automatic logic [SB:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] q;
      logic [SB:0]             res;
      q = (acc + HALF) >>> FRAC;
      if (q > SAT_MAX) begin
         res = {1'b1, SAT_MAX[SB-1:0]};
      end else if (q < SAT_MIN) begin
         res = {1'b1, SAT_MIN[SB-1:0]};
      end else begin
         res = {1'b0, q[SB-1:0]};
      end
      return res;
   endfunction

   // configuration
   assign csr_row  = RW'(32'(tap_address_ff) >> LB);
   assign csr_lane = LW'(32'(tap_address_ff) & (LANES - 1));
   assign tap_wr   = csr_we && (csr_index == sfc_pkg::CSR_TAP_VALUE)
                     && (32'(tap_address_ff) < 32'(MAX_TAPS));

   always_comb begin
      tap_count_in   = tap_count_ff;
      tap_address_in = tap_address_ff;
      if (csr_we && (csr_index == sfc_pkg::CSR_TAP_COUNT)) begin
         tap_count_in = csr_wdata[sfc_pkg::TAP_COUNT_BITS-1:0];
      end
      if (csr_we && (csr_index == sfc_pkg::CSR_TAP_ADDRESS)) begin
         tap_address_in = csr_wdata[sfc_pkg::TAP_ADDR_BITS-1:0];
      end
   end

   // row merge, forwarding the row written at the previous edge
   always_comb begin
      if (last_valid_ff && (last_row_ff == wr_row_ff)) begin
         row_base = last_data_ff;
      end else if (row_valid_ff[wr_row_ff]) begin
         row_base = tap_rdata;
      end else begin
         row_base = '0;
      end
      row_merged = row_base;
      for (int i = 0; i < LANES; i++) begin
         if (LW'(i) == wr_lane_ff) begin
            row_merged[i*SB +: SB] = wr_value_ff;
         end
      end
   end

   always_comb begin
      wr_pend_in    = tap_wr;
      last_valid_in = wr_pend_ff;
      row_valid_in  = row_valid_ff;
      if (wr_pend_ff) begin
         row_valid_in[wr_row_ff] = 1'b1;
      end
   end

   // memories
   assign tap_raddr  = tap_wr ? csr_row : k_row;
   assign hist_wdata = req_tuser ? req_tdata : '0;

   sfc_ram #(
      .WIDTH (LANES * SB),
      .DEPTH (ROWS)
   ) u_tap_ram (
      .clock (clock),
      .we    (wr_pend_ff),
      .waddr (wr_row_ff),
      .wdata (row_merged),
      .raddr (tap_raddr),
      .rdata (tap_rdata)
   );

   sfc_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock (clock),
      .we    (accept),
      .waddr (ptr_ff),
      .wdata (hist_wdata),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   // tap walk addressing
   assign n_full   = (32'(tap_count_ff) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(tap_count_ff);
   assign n_taps   = n_full[CW-1:0];
   assign k_row    = RW'(32'(k_ff) >> LB);
   assign k_lane   = LW'(32'(k_ff) & (LANES - 1));
   assign k_ext    = (CW+1)'(k_ff);
   assign p_ext    = (CW+1)'(ptr_ff);
   assign k_le_p   = (k_ext <= p_ext);
   assign idx_full = k_le_p ? (p_ext - k_ext) : (p_ext + (CW+1)'(MAX_TAPS) - k_ext);
   assign hist_raddr = idx_full[AW-1:0];

   // sequencer
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sfc_pkg::ST_RUN;
            end
         end
         sfc_pkg::ST_RUN: begin
            if (k_ff >= n_taps) begin
               state_in = sfc_pkg::ST_DRAIN;
            end
         end
         sfc_pkg::ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = sfc_pkg::ST_FINISH;
            end
         end
         sfc_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = sfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      issue_en    = 1'b0;
      finish_load = 1'b0;
      case (state_ff)
         sfc_pkg::ST_IDLE: begin
            req_tready = !wr_pend_ff;
         end
         sfc_pkg::ST_RUN: begin
            issue_en = (k_ff < n_taps);
         end
         sfc_pkg::ST_DRAIN: begin
         end
         sfc_pkg::ST_FINISH: begin
            finish_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   assign tap_s    = s1_tap_ok_ff ? tap_rdata[s1_lane_ff*SB +: SB] : '0;
   assign hist_l_s = s1_hist_ok_ff ? hist_rdata[SB-1:0] : '0;
   assign hist_r_s = s1_hist_ok_ff ? hist_rdata[PW-1:SB] : '0;
   assign out_l    = round_sat(acc_l_ff);
   assign out_r    = round_sat(acc_r_ff);

   always_comb begin
      k_in          = k_ff;
      ptr_in        = ptr_ff;
      wrapped_in    = wrapped_ff;
      acc_l_in      = acc_l_ff;
      acc_r_in      = acc_r_ff;
      s1_valid_in   = issue_en;
      s2_valid_in   = s1_valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (accept) begin
         k_in = '0;
         if (req_tuser) begin
            acc_l_in = '0;
            acc_r_in = '0;
         end else begin
            acc_l_in = {{(ACC_W-SB){req_tdata[SB-1]}}, req_tdata[SB-1:0]} <<< FRAC;
            acc_r_in = {{(ACC_W-SB){req_tdata[PW-1]}}, req_tdata[PW-1:SB]} <<< FRAC;
         end
      end else if (s2_valid_ff) begin
         acc_l_in = acc_l_ff + {{(ACC_W-PW){prod_l_ff[PW-1]}}, prod_l_ff};
         acc_r_in = acc_r_ff + {{(ACC_W-PW){prod_r_ff[PW-1]}}, prod_r_ff};
      end
      if (issue_en) begin
         k_in = k_ff + CW'(1);
      end
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (finish_load) begin
         rsp_tvalid_in = 1'b1;
         if (ptr_ff == AW'(MAX_TAPS - 1)) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + AW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sfc_pkg::ST_IDLE;
         tap_count_ff   <= '0;
         tap_address_ff <= '0;
         wr_pend_ff     <= 1'b0;
         last_valid_ff  <= 1'b0;
         row_valid_ff   <= '0;
         k_ff           <= '0;
         ptr_ff         <= '0;
         wrapped_ff     <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tap_count_ff   <= tap_count_in;
         tap_address_ff <= tap_address_in;
         wr_pend_ff     <= wr_pend_in;
         last_valid_ff  <= last_valid_in;
         row_valid_ff   <= row_valid_in;
         k_ff           <= k_in;
         ptr_ff         <= ptr_in;
         wrapped_ff     <= wrapped_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (tap_wr) begin
         wr_row_ff   <= csr_row;
         wr_lane_ff  <= csr_lane;
         wr_value_ff <= csr_wdata[SB-1:0];
      end
      if (wr_pend_ff) begin
         last_row_ff  <= wr_row_ff;
         last_data_ff <= row_merged;
      end
      s1_lane_ff    <= k_lane;
      s1_tap_ok_ff  <= row_valid_ff[k_row];
      s1_hist_ok_ff <= wrapped_ff || k_le_p;
      prod_l_ff     <= tap_s * hist_l_s;
      prod_r_ff     <= tap_s * hist_r_s;
      acc_l_ff      <= acc_l_in;
      acc_r_ff      <= acc_r_in;
      if (finish_load) begin
         rsp_tdata_ff <= {out_r[SB-1:0], out_l[SB-1:0]};
         rsp_tuser_ff <= out_l[SB] | out_r[SB];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== design/sfc_checker.sv =====
// port-level checker for the segment fir convolver, bound to the top level
module sfc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [2*sfc_pkg::SAMPLE_BITS-1:0]    rsp_tdata,
   input logic                                 rsp_tuser
);

   localparam int SB = sfc_pkg::SAMPLE_BITS;
   localparam logic [SB-1:0] POS_LIMIT = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0] NEG_LIMIT = {1'b1, {(SB-1){1'b0}}};

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one transaction in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in flight");

   // a new result only appears after the block was busy
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without work");

   // clipping flag implies a channel sits at a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[SB-1:0] == POS_LIMIT || rsp_tdata[SB-1:0] == NEG_LIMIT ||
         rsp_tdata[2*SB-1:SB] == POS_LIMIT || rsp_tdata[2*SB-1:SB] == NEG_LIMIT)
      else $error("saturated flag without a clipped channel");

endmodule

bind segment_fir_convolver sfc_checker u_sfc_checker (.*);
